// ----- rtl/pulse_width_search_sequencer_assert.svh -----
// Assertion macros for the pulse-width search sequencer.
// Uses clk and arst_n of the including module; empty when SYNTH is defined.
`ifndef PULSE_WIDTH_SEARCH_SEQUENCER_ASSERT_SVH
`define PULSE_WIDTH_SEARCH_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// check a property on every rising edge outside reset
`define PWSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// check that a condition never holds outside reset
`define PWSS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define PWSS_ASSERT(label, prop, msg)
`define PWSS_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- rtl/pwss_pkg.sv -----
// Shared types, constants and helpers of the pulse-width search sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package pwss_pkg;

	// field widths
	localparam int unsigned CntW   = 8;
	localparam int unsigned MissW  = 16;
	localparam int unsigned WidthW = 31;
	localparam int unsigned StepW  = 16;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 31;

	// saturation limits and reset values
	localparam logic [CntW-1:0]   CNT_MAX   = 8'hFF;
	localparam logic [MissW-1:0]  MISS_MAX  = 16'hFFFF;
	localparam logic [WidthW-1:0] WIDTH_MAX = 31'h7FFF_FFFF;

	localparam logic [CntW-1:0]   DEBOUNCE_LIMIT_RST = 8'd100;
	localparam logic [MissW-1:0]  MISS_LIMIT_RST     = 16'd1000;
	localparam logic [WidthW-1:0] START_WIDTH_RST    = 31'd100000000;
	localparam logic [StepW-1:0]  WIDTH_STEP_RST     = 16'd100;

	// mode codes on the result
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ALIGN = 2'd1;
	localparam logic [1:0] MODE_DOWN  = 2'd2;
	localparam logic [1:0] MODE_UP    = 2'd3;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE_LIMIT = 2'd0,
		REG_MISS_LIMIT     = 2'd1,
		REG_START_WIDTH    = 2'd2,
		REG_WIDTH_STEP     = 2'd3
	} cfg_idx_t;

	// sequencer state
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ALIGN = 4'b0010,
		ST_DOWN  = 4'b0100,
		ST_UP    = 4'b1000
	} seq_state_t;

	typedef struct packed {
		logic [CntW-1:0]   debounce_limit;
		logic [MissW-1:0]  miss_limit;
		logic [WidthW-1:0] start_width;
		logic [StepW-1:0]  width_step;
	} cfg_t;

	typedef struct packed {
		logic button_one_down;
		logic button_two_down;
		logic detector_level;
		logic detector_rose;
		logic pulse_timer_done;
	} item_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              laser_steady_on;
		logic              fire_pulse;
		logic [WidthW-1:0] fire_width;
		logic [WidthW:0]   fire_period;
		logic              report_valid;
		logic [WidthW-1:0] report_width;
		logic              report_final;
		logic              aligned_event;
	} res_t;

	// map a state to its mode code
	function automatic logic [1:0] mode_code(input seq_state_t st);
		logic [1:0] code;
		unique case (st)
			ST_IDLE:  code = MODE_IDLE;
			ST_ALIGN: code = MODE_ALIGN;
			ST_DOWN:  code = MODE_DOWN;
			ST_UP:    code = MODE_UP;
			default:  code = MODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pulse_width_search_sequencer.sv -----
// Top level of the pulse-width search sequencer: input and result registers,
// handshakes, and the config and core instances. Depends on pwss_pkg.
//
//  channel  | signals                            | direction
//  ---------+------------------------------------+----------
//  input    | in_valid/in_ready, five tick bits  | in
//  result   | out_valid/out_ready, nine fields   | out
//  config   | cfg_valid/cfg_ready, index, data   | in
//
// One tick is accepted per cycle while in_ready is high; its result passes
// through the input register, then the result register, with the step logic
// between them, and waits there to be taken. Reset clears the
// state, loads the register defaults and needs no clearing pass. With out_ready
// low the result holds, one more beat waits in the input register, and in_ready
// then drops until the result goes.
`default_nettype none
`include "pulse_width_search_sequencer_assert.svh"

module pulse_width_search_sequencer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             button_one_down,
	input  wire logic                             button_two_down,
	input  wire logic                             detector_level,
	input  wire logic                             detector_rose,
	input  wire logic                             pulse_timer_done,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [1:0]                            mode,
	output logic                                  laser_steady_on,
	output logic                                  fire_pulse,
	output logic [pwss_pkg::WidthW-1:0]           fire_width,
	output logic [pwss_pkg::WidthW:0]             fire_period,
	output logic                                  report_valid,
	output logic [pwss_pkg::WidthW-1:0]           report_width,
	output logic                                  report_final,
	output logic                                  aligned_event,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pwss_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [pwss_pkg::CfgDataW-1:0]    cfg_data
);

	pwss_pkg::cfg_t  cfg;
	pwss_pkg::item_t item_s1;
	pwss_pkg::res_t  res, res_s2;
	logic            valid_s1, valid_s2, adv;

	// move a beat into the result register when it is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.button_one_down  <= button_one_down;
			item_s1.button_two_down  <= button_two_down;
			item_s1.detector_level   <= detector_level;
			item_s1.detector_rose    <= detector_rose;
			item_s1.pulse_timer_done <= pulse_timer_done;
		end
	end

	pwss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwss_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign mode            = res_s2.mode;
	assign laser_steady_on = res_s2.laser_steady_on;
	assign fire_pulse      = res_s2.fire_pulse;
	assign fire_width      = res_s2.fire_width;
	assign fire_period     = res_s2.fire_period;
	assign report_valid    = res_s2.report_valid;
	assign report_width    = res_s2.report_width;
	assign report_final    = res_s2.report_final;
	assign aligned_event   = res_s2.aligned_event;

	`PWSS_ASSERT(a_final_idle,
		out_valid && report_final |-> report_valid && (mode == pwss_pkg::MODE_IDLE),
		"final report without idle mode")
	`PWSS_ASSERT(a_laser_align,
		out_valid && laser_steady_on |-> mode == pwss_pkg::MODE_ALIGN,
		"laser on outside align")
	`PWSS_ASSERT_NEVER(a_align_fire,
		out_valid && aligned_event && fire_pulse,
		"alignment and pulse in one tick")

endmodule

`default_nettype wire

// ----- rtl/pwss_cfg.sv -----
// Configuration register file of the pulse-width search sequencer.
// Depends on pwss_pkg.
`default_nettype none

module pwss_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pwss_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [pwss_pkg::CfgDataW-1:0]     cfg_data,
	output pwss_pkg::cfg_t                         cfg
);

	pwss_pkg::cfg_t cfg_q;
	pwss_pkg::cfg_idx_t idx;

	// writes are always accepted
	assign cfg_ready = 1'b1;
	assign idx = pwss_pkg::cfg_idx_t'(cfg_index);

	// store a written beat into the selected register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_limit <= pwss_pkg::DEBOUNCE_LIMIT_RST;
			cfg_q.miss_limit     <= pwss_pkg::MISS_LIMIT_RST;
			cfg_q.start_width    <= pwss_pkg::START_WIDTH_RST;
			cfg_q.width_step     <= pwss_pkg::WIDTH_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (idx)
				pwss_pkg::REG_DEBOUNCE_LIMIT:
					cfg_q.debounce_limit <= cfg_data[pwss_pkg::CntW-1:0];
				pwss_pkg::REG_MISS_LIMIT:
					cfg_q.miss_limit <= cfg_data[pwss_pkg::MissW-1:0];
				pwss_pkg::REG_START_WIDTH:
					cfg_q.start_width <= cfg_data[pwss_pkg::WidthW-1:0];
				pwss_pkg::REG_WIDTH_STEP:
					cfg_q.width_step <= cfg_data[pwss_pkg::StepW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/pwss_core.sv -----
// Per-tick sequencer: debounce, mode selection, search and align logic,
// with the state registers it updates. Depends on pwss_pkg.
`default_nettype none
`include "pulse_width_search_sequencer_assert.svh"

module pwss_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire pwss_pkg::item_t     item,
	input  wire pwss_pkg::cfg_t      cfg,
	output pwss_pkg::res_t           res
);

	pwss_pkg::seq_state_t state_q, state_mid, state_d;
	logic [pwss_pkg::CntW-1:0]   cnt_one_q, cnt_two_q, cnt_one_inc, cnt_two_inc;
	logic [pwss_pkg::CntW-1:0]   cnt_one_d, cnt_two_d;
	logic [1:0]                  stable_q, prev_q, stable_d;
	logic [pwss_pkg::WidthW-1:0] width_q, width_mid, width_d, half_width, up_width;
	logic [pwss_pkg::WidthW:0]   up_sum;
	logic [pwss_pkg::MissW-1:0]  miss_q, miss_d, miss_inc;
	logic                        seen_q, seen_pre, seen_mid, seen_d;
	logic                        changed, start_fire, timer_eff;

	// debounce both buttons with saturating counters
	assign cnt_one_inc = (cnt_one_q == pwss_pkg::CNT_MAX) ? cnt_one_q : cnt_one_q + 8'd1;
	assign cnt_two_inc = (cnt_two_q == pwss_pkg::CNT_MAX) ? cnt_two_q : cnt_two_q + 8'd1;
	assign cnt_one_d   = item.button_one_down ? cnt_one_inc : '0;
	assign cnt_two_d   = item.button_two_down ? cnt_two_inc : '0;
	assign stable_d[0] = item.button_one_down
		& (stable_q[0] | (cnt_one_inc > cfg.debounce_limit));
	assign stable_d[1] = item.button_two_down
		& (stable_q[1] | (cnt_two_inc > cfg.debounce_limit));
	assign changed     = (stable_d != prev_q);

	// latch the detector edge before anything else this tick
	assign seen_pre = seen_q | item.detector_rose;

	// arithmetic for the search arms
	assign miss_inc   = (miss_q == pwss_pkg::MISS_MAX) ? miss_q : miss_q + 16'd1;
	assign half_width = width_mid >> 1;
	assign up_sum     = {1'b0, width_mid} + {{(pwss_pkg::WidthW + 1 - pwss_pkg::StepW){1'b0}},
		cfg.width_step};
	assign up_width   = up_sum[pwss_pkg::WidthW] ? pwss_pkg::WIDTH_MAX
		: up_sum[pwss_pkg::WidthW-1:0];

	// pick the mode on a debounced change; button one wins
	always_comb begin
		state_mid  = state_q;
		width_mid  = width_q;
		seen_mid   = seen_pre;
		start_fire = 1'b0;
		timer_eff  = item.pulse_timer_done;
		if (changed) begin
			if (stable_d[0]) begin
				state_mid = pwss_pkg::ST_ALIGN;
			end else if (stable_d[1]) begin
				state_mid  = pwss_pkg::ST_DOWN;
				width_mid  = cfg.start_width;
				seen_mid   = 1'b0;
				start_fire = 1'b1;
				timer_eff  = 1'b0;
			end
		end
	end

	// run the active mode
	always_comb begin
		state_d = state_mid;
		width_d = width_mid;
		seen_d  = seen_mid;
		miss_d  = miss_q;
		res     = '0;
		res.fire_pulse = start_fire;
		res.fire_width = start_fire ? cfg.start_width : '0;
		unique case (state_mid)
			pwss_pkg::ST_ALIGN: begin
				if (item.detector_level) begin
					res.aligned_event = 1'b1;
					state_d = pwss_pkg::ST_IDLE;
				end else begin
					res.laser_steady_on = 1'b1;
				end
			end
			pwss_pkg::ST_DOWN: begin
				if (seen_mid && timer_eff) begin
					seen_d = 1'b0;
					miss_d = '0;
					res.report_valid = 1'b1;
					res.report_width = width_mid;
					width_d = half_width;
					res.fire_pulse = 1'b1;
					res.fire_width = half_width;
				end else if (timer_eff) begin
					miss_d = miss_inc;
					if (miss_inc > cfg.miss_limit) begin
						state_d = pwss_pkg::ST_UP;
					end
				end
			end
			pwss_pkg::ST_UP: begin
				if (!seen_mid && timer_eff) begin
					miss_d = '0;
					res.report_valid = 1'b1;
					res.report_width = width_mid;
					width_d = up_width;
					res.fire_pulse = 1'b1;
					res.fire_width = up_width;
				end else if (seen_mid) begin
					res.report_valid = 1'b1;
					res.report_final = 1'b1;
					res.report_width = width_mid;
					state_d = pwss_pkg::ST_IDLE;
				end
			end
			pwss_pkg::ST_IDLE: ;
			default: ;
		endcase
		res.mode        = pwss_pkg::mode_code(state_d);
		res.fire_period = {res.fire_width, 1'b0};
	end

	// commit the tick's state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pwss_pkg::ST_IDLE;
			cnt_one_q <= '0;
			cnt_two_q <= '0;
			stable_q  <= '0;
			prev_q    <= '0;
			width_q   <= pwss_pkg::START_WIDTH_RST;
			miss_q    <= '0;
			seen_q    <= 1'b0;
		end else if (adv) begin
			state_q   <= state_d;
			cnt_one_q <= cnt_one_d;
			cnt_two_q <= cnt_two_d;
			stable_q  <= stable_d;
			prev_q    <= stable_d;
			width_q   <= width_d;
			miss_q    <= miss_d;
			seen_q    <= seen_d;
		end
	end

	`PWSS_ASSERT(a_miss_clear,
		adv && res.report_valid && !res.report_final |=> miss_q == '0,
		"miss count not cleared after a report")
	`PWSS_ASSERT(a_final_from_up,
		adv && res.report_final |-> state_q == pwss_pkg::ST_UP,
		"final report outside upward search")
	`PWSS_ASSERT(a_down_halves,
		adv && res.report_valid && (res.mode == pwss_pkg::MODE_DOWN)
		|=> width_q == ($past(res.report_width) >> 1),
		"downward step did not halve width")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for pulse_width_search_sequencer: a queue-fed tick driver,
// a result monitor and a per-tick predictor of the mode logic.
// Depends on pwss_pkg and the sequencer RTL only.

module tb;

	localparam int WATCHDOG_LIMIT = 2000;

	// scenario kinds for the tick generator
	localparam int SCN_ALIGN  = 0;
	localparam int SCN_SEARCH = 1;
	localparam int SCN_NOISE  = 2;

	// sender idle and receiver stall percentages, one pair per pace setting
	int idle_table [4] = '{0, 52, 0, 28};
	int stall_table [4] = '{0, 0, 52, 28};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic button_one_down = 1'b0;
	logic button_two_down = 1'b0;
	logic detector_level = 1'b0;
	logic detector_rose = 1'b0;
	logic pulse_timer_done = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] mode;
	logic laser_steady_on;
	logic fire_pulse;
	logic [pwss_pkg::WidthW-1:0] fire_width;
	logic [pwss_pkg::WidthW:0] fire_period;
	logic report_valid;
	logic [pwss_pkg::WidthW-1:0] report_width;
	logic report_final;
	logic aligned_event;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	pwss_pkg::cfg_idx_t cfg_index = pwss_pkg::REG_DEBOUNCE_LIMIT;
	logic [pwss_pkg::CfgDataW-1:0] cfg_data = '0;

	pwss_pkg::item_t tick_queue [$];
	pwss_pkg::res_t tick_results [$];
	pwss_pkg::item_t drive_item;
	pwss_pkg::res_t want;
	logic in_taken = 1'b0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int queued = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	// predictor copy of the registers
	logic [pwss_pkg::CntW-1:0] lim_debounce = pwss_pkg::DEBOUNCE_LIMIT_RST;
	logic [pwss_pkg::MissW-1:0] lim_miss = pwss_pkg::MISS_LIMIT_RST;
	logic [pwss_pkg::WidthW-1:0] width_start = pwss_pkg::START_WIDTH_RST;
	logic [pwss_pkg::StepW-1:0] width_inc = pwss_pkg::WIDTH_STEP_RST;

	// predictor copy of the state
	logic [1:0] mode_q = pwss_pkg::MODE_IDLE;
	logic [pwss_pkg::CntW-1:0] press_cnt [2] = '{8'd0, 8'd0};
	logic [1:0] stable_q = 2'b00;
	logic [1:0] prev_q = 2'b00;
	logic [pwss_pkg::WidthW-1:0] width_q = pwss_pkg::START_WIDTH_RST;
	logic [pwss_pkg::MissW-1:0] miss_q = '0;
	logic seen_q = 1'b0;

	pulse_width_search_sequencer i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the predicted sequencer by one tick and return its outputs
	function automatic pwss_pkg::res_t advance_tick(input pwss_pkg::item_t it);
		pwss_pkg::res_t r;
		logic done;
		logic [1:0] pressed;
		r = '0;
		done = it.pulse_timer_done;
		pressed = {it.button_two_down, it.button_one_down};
		if (it.detector_rose)
			seen_q = 1'b1;
		// debounce both buttons with saturating counters
		for (int b = 0; b < 2; b++) begin
			if (pressed[b]) begin
				if (press_cnt[b] != pwss_pkg::CNT_MAX)
					press_cnt[b] = press_cnt[b] + 1'b1;
				if (press_cnt[b] > lim_debounce)
					stable_q[b] = 1'b1;
			end else begin
				press_cnt[b] = '0;
				stable_q[b] = 1'b0;
			end
		end
		// a debounced change picks the mode; button one wins
		if (stable_q != prev_q) begin
			prev_q = stable_q;
			if (stable_q[0]) begin
				mode_q = pwss_pkg::MODE_ALIGN;
			end else if (stable_q[1]) begin
				width_q = width_start;
				seen_q = 1'b0;
				r.fire_pulse = 1'b1;
				r.fire_width = width_q;
				done = 1'b0;
				mode_q = pwss_pkg::MODE_DOWN;
			end
		end
		case (mode_q)
			pwss_pkg::MODE_ALIGN: begin
				if (it.detector_level) begin
					r.aligned_event = 1'b1;
					mode_q = pwss_pkg::MODE_IDLE;
				end else begin
					r.laser_steady_on = 1'b1;
				end
			end
			pwss_pkg::MODE_DOWN: begin
				if (seen_q && done) begin
					seen_q = 1'b0;
					miss_q = '0;
					r.report_valid = 1'b1;
					r.report_width = width_q;
					width_q = width_q >> 1;
					r.fire_pulse = 1'b1;
					r.fire_width = width_q;
				end else if (done) begin
					if (miss_q != pwss_pkg::MISS_MAX)
						miss_q = miss_q + 1'b1;
					if (miss_q > lim_miss)
						mode_q = pwss_pkg::MODE_UP;
				end
			end
			pwss_pkg::MODE_UP: begin
				if (!seen_q && done) begin
					miss_q = '0;
					r.report_valid = 1'b1;
					r.report_width = width_q;
					if (width_q > pwss_pkg::WIDTH_MAX - {15'd0, width_inc})
						width_q = pwss_pkg::WIDTH_MAX;
					else
						width_q = width_q + {15'd0, width_inc};
					r.fire_pulse = 1'b1;
					r.fire_width = width_q;
				end else if (seen_q) begin
					r.report_valid = 1'b1;
					r.report_final = 1'b1;
					r.report_width = width_q;
					mode_q = pwss_pkg::MODE_IDLE;
				end
			end
			default: begin
			end
		endcase
		r.mode = mode_q;
		r.fire_period = {r.fire_width, 1'b0};
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			fail_count++;
		end
	endtask

	// driver: present the next tick on the falling edge, idling at random
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				drive_item = tick_queue.pop_front();
				in_valid <= 1'b1;
				button_one_down <= drive_item.button_one_down;
				button_two_down <= drive_item.button_two_down;
				detector_level <= drive_item.detector_level;
				detector_rose <= drive_item.detector_rose;
				pulse_timer_done <= drive_item.pulse_timer_done;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// monitor: check result beats, then predict each accepted tick
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (tick_results.size() == 0) begin
					$error("result beat with no tick outstanding");
					fail_count++;
				end else begin
					want = tick_results.pop_front();
					compare_field("mode", want.mode, mode);
					compare_field("laser_steady_on", want.laser_steady_on, laser_steady_on);
					compare_field("fire_pulse", want.fire_pulse, fire_pulse);
					compare_field("fire_width", want.fire_width, fire_width);
					compare_field("fire_period", want.fire_period, fire_period);
					compare_field("report_valid", want.report_valid, report_valid);
					compare_field("report_width", want.report_width, report_width);
					compare_field("report_final", want.report_final, report_final);
					compare_field("aligned_event", want.aligned_event, aligned_event);
				end
			end
			if (in_valid && in_ready)
				tick_results.push_back(advance_tick({button_one_down, button_two_down,
					detector_level, detector_rose, pulse_timer_done}));
		end
	end

	// count cycles without any beat on any channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$error("no beat for %0d cycles", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic push_tick(input logic b1, input logic b2, input logic lvl,
			input logic rose, input logic done);
		tick_queue.push_back({b1, b2, lvl, rose, done});
		queued++;
	endtask

	task automatic write_reg(input pwss_pkg::cfg_idx_t idx,
			input logic [pwss_pkg::CfgDataW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pwss_pkg::REG_DEBOUNCE_LIMIT: lim_debounce = value[pwss_pkg::CntW-1:0];
			pwss_pkg::REG_MISS_LIMIT:     lim_miss = value[pwss_pkg::MissW-1:0];
			pwss_pkg::REG_START_WIDTH:    width_start = value[pwss_pkg::WidthW-1:0];
			pwss_pkg::REG_WIDTH_STEP:     width_inc = value[pwss_pkg::StepW-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input logic [pwss_pkg::CntW-1:0] dl,
			input logic [pwss_pkg::MissW-1:0] ml,
			input logic [pwss_pkg::WidthW-1:0] sw,
			input logic [pwss_pkg::StepW-1:0] ws);
		write_reg(pwss_pkg::REG_DEBOUNCE_LIMIT, {23'd0, dl});
		write_reg(pwss_pkg::REG_MISS_LIMIT, {15'd0, ml});
		write_reg(pwss_pkg::REG_START_WIDTH, sw);
		write_reg(pwss_pkg::REG_WIDTH_STEP, {15'd0, ws});
	endtask

	task automatic set_pace(input int sel);
		sender_idle_pct = idle_table[sel];
		receiver_stall_pct = stall_table[sel];
	endtask

	// hold the sender until every tick is in and every result is out
	task automatic settle();
		do @(posedge clk); while (tick_queue.size() != 0 || in_valid || tick_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// queue a button press and the ticks that follow it
	task automatic queue_scenario(input int kind);
		int hold;
		int span;
		int rose_pct;
		hold = int'(lim_debounce) + 1 + $urandom_range(2);
		case (kind)
			SCN_ALIGN: begin
				for (int i = 0; i < hold; i++)
					push_tick(1'b1, 1'b0, 1'b0, $urandom_range(1), $urandom_range(1));
				span = $urandom_range(4);
				for (int i = 0; i < span; i++)
					push_tick(1'b1, 1'b0, 1'b0, $urandom_range(1), $urandom_range(1));
				push_tick($urandom_range(1), 1'b0, 1'b1, $urandom_range(1), $urandom_range(1));
				push_tick(1'b0, 1'b0, $urandom_range(1), $urandom_range(1), $urandom_range(1));
			end
			SCN_SEARCH: begin
				rose_pct = 10 + 20 * $urandom_range(2);
				for (int i = 0; i < hold; i++)
					push_tick(1'b0, 1'b1, $urandom_range(1), $urandom_range(1),
						$urandom_range(1));
				span = $urandom_range(8, 40);
				for (int i = 0; i < span; i++)
					push_tick(1'b0, $urandom_range(15) == 0, $urandom_range(1),
						$urandom_range(99) < rose_pct, $urandom_range(99) < 60);
				// close an upward search with a detection
				push_tick(1'b0, 1'b0, $urandom_range(1), 1'b1, 1'b0);
			end
			default: begin
				span = $urandom_range(3, 10);
				for (int i = 0; i < span; i++)
					push_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
						$urandom_range(1), $urandom_range(1));
			end
		endcase
	endtask

	initial begin
		int r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults straight out of reset
		set_pace(1);
		queue_scenario(SCN_SEARCH);
		settle();

		// directed walk: align, halving to the floor, turn up, restarts
		set_pace(0);
		load_config(8'd0, 16'd1, 31'd3, 16'd65535);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
		push_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
		push_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		push_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
		settle();

		// widest start, largest step: the upward search pins at the ceiling
		set_pace(2);
		load_config(8'd2, 16'd0, pwss_pkg::WIDTH_MAX, 16'd65535);
		queue_scenario(SCN_SEARCH);
		queue_scenario(SCN_SEARCH);
		settle();

		// random phases with short debounce and miss limits
		for (int p = 0; p < 8; p++) begin
			set_pace(p % 4);
			load_config($urandom_range(3), $urandom_range(6),
				$urandom_range(1) ? $urandom_range(1, 40) : $urandom_range(1, 32'h7FFF_FFFF),
				$urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 65535));
			queued = 0;
			while (queued < 20) begin
				r = $urandom_range(9);
				queue_scenario(r < 2 ? SCN_ALIGN : (r < 8 ? SCN_SEARCH : SCN_NOISE));
			end
			settle();
		end

		// catch any stray result beat
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pwss_pkg.sv
rtl/pwss_cfg.sv
rtl/pwss_core.sv
rtl/pulse_width_search_sequencer.sv
tb/sv/tb.sv
